// ===== rtl/dcks_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dcks_pkg;

	// Defaults for the top-level parameters.
	localparam int NUM_CHUNKS_DEF = 11;
	localparam int TIMER_W_DEF    = 16;

	// Fixed geometry of one scan and of the fields.
	localparam int KEYS_PER_CHUNK = 8;
	localparam int KEY_IDX_W      = 3;
	localparam int CHUNK_NUM_W    = 4;
	localparam int KEY_NUM_W      = 7;
	localparam int TRAVEL_W       = 16;

	// What one lane found for its key in the current scan.
	typedef struct packed {
		logic                note_off;
		logic                note_on;
		logic [TRAVEL_W-1:0] travel;
	} lane_evt_t;

	// Control handed from the front stage to every lane.
	typedef struct packed {
		logic update;     // scan leaves the front stage and is in range
		logic any_first;  // at least one first contact closed
		logic seen_nz;    // stored first-contact byte of the chunk is nonzero
	} lane_ctl_t;

	// Position of the lowest set bit of a key mask.
	function automatic logic [KEY_IDX_W-1:0] lowest_set(input logic [KEYS_PER_CHUNK-1:0] m);
		logic [KEY_IDX_W-1:0] idx;
		idx = '0;
		for (int i = KEYS_PER_CHUNK - 1; i >= 0; i--) begin
			if (m[i]) begin
				idx = KEY_IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/dcks_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dcks_lane
	import dcks_pkg::*;
#(
	parameter int NUM_CHUNKS  = NUM_CHUNKS_DEF,
	parameter int TIMER_WIDTH = TIMER_W_DEF,
	localparam int CHUNK_IDX_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire lane_ctl_t              ctl,
	input  wire logic [CHUNK_IDX_W-1:0] chunk_idx,
	input  wire logic                   first_bit,
	input  wire logic                   second_bit,
	output lane_evt_t                   evt
);

	// State of this key position in every chunk.
	logic                   pressed_q [NUM_CHUNKS];
	logic [TIMER_WIDTH-1:0] timer_q   [NUM_CHUNKS];

	logic                   pressed;
	logic [TIMER_WIDTH-1:0] timer;
	logic                   pressed_nx;
	logic [TIMER_WIDTH-1:0] timer_nx;

	assign pressed = pressed_q[chunk_idx];
	assign timer   = timer_q[chunk_idx];

	// Events and next state for the addressed key.
	always_comb begin
		evt.note_off = 1'b0;
		evt.note_on  = 1'b0;
		evt.travel   = TRAVEL_W'(timer);
		pressed_nx   = pressed;
		timer_nx     = timer;
		if (ctl.any_first) begin
			if (pressed && !first_bit) begin
				evt.note_off = 1'b1;
				pressed_nx   = 1'b0;
				timer_nx     = '0;
			end else if (first_bit) begin
				if (second_bit) begin
					if (!pressed) begin
						evt.note_on = 1'b1;
						pressed_nx  = 1'b1;
						timer_nx    = '0;
					end
				end else if (timer != '1) begin
					timer_nx = timer + TIMER_WIDTH'(1);
				end
			end
		end else if (ctl.seen_nz) begin
			evt.note_off = pressed;
			pressed_nx   = 1'b0;
			timer_nx     = '0;
		end
	end

	// Write back when the scan leaves the front stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHUNKS; c++) begin
				pressed_q[c] <= 1'b0;
				timer_q[c]   <= '0;
			end
		end else if (ctl.update) begin
			pressed_q[chunk_idx] <= pressed_nx;
			timer_q[chunk_idx]   <= timer_nx;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dcks_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dcks_merge
	import dcks_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load,
	input  wire logic [CHUNK_NUM_W-1:0] load_chunk,
	input  wire lane_evt_t              lane_evt [KEYS_PER_CHUNK],
	output logic                        can_load,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [23:0]                 m_axis_tdata,
	output logic [0:0]                  m_axis_tuser,
	output logic                        m_axis_tlast
);

	// Pending events of one scan, sent one beat at a time.
	logic [KEYS_PER_CHUNK-1:0] off_q;
	logic [KEYS_PER_CHUNK-1:0] on_q;
	logic [TRAVEL_W-1:0]       travel_q [KEYS_PER_CHUNK];
	logic [CHUNK_NUM_W-1:0]    chunk_q;

	logic [KEYS_PER_CHUNK-1:0] rest;
	logic                      use_off;
	logic [KEY_IDX_W-1:0]      sel;
	logic                      last;
	logic                      take;

	// Note-offs before note-ons, each in ascending key order.
	assign rest    = off_q | on_q;
	assign use_off = |off_q;
	assign sel     = use_off ? lowest_set(off_q) : lowest_set(on_q);
	assign last    = (rest & (rest - KEYS_PER_CHUNK'(1))) == '0;
	assign take    = m_axis_tvalid && m_axis_tready;

	assign m_axis_tvalid = |rest;
	assign m_axis_tdata  = {1'b0, travel_q[sel], chunk_q, sel};
	assign m_axis_tuser  = use_off;
	assign m_axis_tlast  = last;
	assign can_load      = !m_axis_tvalid || (take && last);

	// Masks: load a new scan, otherwise retire the beat just taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			on_q  <= '0;
		end else if (load) begin
			for (int i = 0; i < KEYS_PER_CHUNK; i++) begin
				off_q[i] <= lane_evt[i].note_off;
				on_q[i]  <= lane_evt[i].note_on;
			end
		end else if (take) begin
			if (use_off) begin
				off_q[sel] <= 1'b0;
			end else begin
				on_q[sel] <= 1'b0;
			end
		end
	end

	// Event payload of the loaded scan.
	always_ff @(posedge clk) begin
		if (load) begin
			chunk_q <= load_chunk;
			for (int i = 0; i < KEYS_PER_CHUNK; i++) begin
				travel_q[i] <= lane_evt[i].travel;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dual_contact_key_scanner_core.sv =====
// Channel   Direction  tdata (low bit up)                          tuser        tlast
// s_axis    in         chunk_number 4, first_contacts 8,           -            -
//                      second_contacts 8, pad 4
// m_axis    out        key_number 7, travel_time 16, pad 1         is_release   last_event
//
// A scan is registered on acceptance; eight key lanes then evaluate it combinationally
// and write their state back, and the events go to the output serialiser.
// A scan with n events occupies the output for n beats (one beat per cycle while
// m_axis_tready is high); a scan with no events leaves without waiting for the output.
// A next scan with events waits in the front register while events are still being sent.
// Reset clears all key state and stored first-contact bytes at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module dual_contact_key_scanner_core
	import dcks_pkg::*;
#(
	parameter int NUM_CHUNKS  = NUM_CHUNKS_DEF,
	parameter int TIMER_WIDTH = TIMER_W_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // chunk_number, first_contacts, second_contacts
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // key_number, travel_time
	output logic [0:0]       m_axis_tuser,   // is_release
	output logic             m_axis_tlast    // last_event
);

	localparam int CHUNK_IDX_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

	// Front stage holding one accepted scan.
	logic                      valid_s1;
	logic [CHUNK_NUM_W-1:0]    chunk_s1;
	logic [KEYS_PER_CHUNK-1:0] first_s1;
	logic [KEYS_PER_CHUNK-1:0] second_s1;

	logic [KEYS_PER_CHUNK-1:0] first_seen_q [NUM_CHUNKS];

	logic [CHUNK_IDX_W-1:0] chunk_idx;
	logic                   in_range;
	logic                   has_evt;
	logic                   can_load;
	logic                   advance;
	lane_ctl_t              ctl;
	lane_evt_t              lane_evt [KEYS_PER_CHUNK];

	assign chunk_idx = chunk_s1[CHUNK_IDX_W-1:0];
	assign in_range  = {1'b0, chunk_s1} < (CHUNK_NUM_W + 1)'(NUM_CHUNKS);

	// A scan without events never waits for the serialiser.
	// A chunk beyond the keyboard has no events, whatever the lanes show.
	always_comb begin
		has_evt = 1'b0;
		for (int i = 0; i < KEYS_PER_CHUNK; i++) begin
			has_evt = has_evt | lane_evt[i].note_off | lane_evt[i].note_on;
		end
		has_evt = has_evt && in_range;
	end

	assign advance       = valid_s1 && (can_load || !has_evt);
	assign s_axis_tready = !valid_s1 || advance;

	assign ctl.update    = advance && in_range;
	assign ctl.any_first = |first_s1;
	assign ctl.seen_nz   = |first_seen_q[chunk_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			chunk_s1  <= s_axis_tdata[3:0];
			first_s1  <= s_axis_tdata[11:4];
			second_s1 <= s_axis_tdata[19:12];
		end
	end

	// Last first-contact byte of every chunk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHUNKS; c++) begin
				first_seen_q[c] <= '0;
			end
		end else if (ctl.update) begin
			first_seen_q[chunk_idx] <= first_s1;
		end
	end

	// One lane per key position of the chunk.
	for (genvar g = 0; g < KEYS_PER_CHUNK; g++) begin : g_lane
		dcks_lane #(
			.NUM_CHUNKS  (NUM_CHUNKS),
			.TIMER_WIDTH (TIMER_WIDTH)
		) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.chunk_idx  (chunk_idx),
			.first_bit  (first_s1[g]),
			.second_bit (second_s1[g]),
			.evt        (lane_evt[g])
		);
	end

	// Ordering and serialising of the lane events.
	dcks_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (ctl.update && has_evt),
		.load_chunk    (chunk_s1),
		.lane_evt      (lane_evt),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire
